// ===== hdl/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg - shared types and constants of the I2C bit-level master
// Opcodes, item classes, phase descriptions and the phase table function.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // tick counter width; phase lengths never exceed the 16-bit registers
  localparam int TICK_W = 16;

  // opcodes of the command channel
  localparam logic [3:0] OP_TICK    = 4'd0;
  localparam logic [3:0] OP_RECOVER = 4'd1;
  localparam logic [3:0] OP_START   = 4'd2;
  localparam logic [3:0] OP_STOP    = 4'd3;
  localparam logic [3:0] OP_WRITE   = 4'd4;
  localparam logic [3:0] OP_READ    = 4'd5;
  localparam logic [3:0] OP_ACK     = 4'd6;
  localparam logic [3:0] OP_NACK    = 4'd7;
  localparam logic [3:0] OP_SACK    = 4'd8;

  // idle value of the active command register
  localparam logic [3:0] CMD_IDLE   = 4'd0;

  // item classes set by the front end
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PHASE  = 2'd0;
  localparam logic [1:0] CFG_EXTRA  = 2'd1;
  localparam logic [1:0] CFG_ACKHI  = 2'd2;
  localparam logic [1:0] CFG_PULSES = 2'd3;

  // line drive codes
  localparam logic [1:0] LV_LO      = 2'd0;
  localparam logic [1:0] LV_HI      = 2'd1;
  localparam logic [1:0] LV_HOLD    = 2'd2;

  // phase length selectors
  localparam logic [1:0] LEN_P      = 2'd0;
  localparam logic [1:0] LEN_E      = 2'd1;
  localparam logic [1:0] LEN_A      = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] opcode;
    logic [7:0] wr_data;
    logic       sda_in;
  } qitem_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] extra_ticks;
    logic [15:0] ack_ticks;
    logic [4:0]  pulses;
  } cfg_t;

  typedef struct packed {
    logic [1:0] sda;
    logic [1:0] scl;
    logic [1:0] len_sel;
    logic       sample;
  } phase_t;

  function automatic phase_t mk(input logic [1:0] sda, input logic [1:0] scl,
                                input logic [1:0] len_sel, input logic sample);
    phase_t p;
    p.sda     = sda;
    p.scl     = scl;
    p.len_sel = len_sel;
    p.sample  = sample;
    return p;
  endfunction

  // line levels, length and sampling of phase idx of command cmd
  // d is the current data bit, lv the level driven in the ack slot
  function automatic phase_t phase_desc(input logic [3:0] cmd, input logic [5:0] idx,
                                        input logic d, input logic lv);
    phase_t     p;
    logic [1:0] dv;
    logic [1:0] lvv;
    dv  = {1'b0, d};
    lvv = {1'b0, lv};
    case (cmd)
      OP_RECOVER: begin
        case (idx)
          6'd0:    p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
          6'd1:    p = mk(LV_LO,   LV_LO,   LEN_P, 1'b0);
          6'd2:    p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
          6'd3:    p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
          6'd4:    p = mk(LV_HI,   LV_HI,   LEN_P, 1'b0);
          6'd5:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          6'd6:    p = mk(LV_LO,   LV_HOLD, LEN_P, 1'b0);
          6'd7:    p = mk(LV_LO,   LV_HI,   LEN_P, 1'b0);
          default: p = mk(LV_HI,   LV_HI,   LEN_P, 1'b0);
        endcase
      end
      OP_START: begin
        case (idx)
          6'd0:    p = mk(LV_HI, LV_HOLD, LEN_P, 1'b0);
          6'd1:    p = mk(LV_HI, LV_HI,   LEN_P, 1'b0);
          default: p = mk(LV_LO, LV_HI,   LEN_P, 1'b0);
        endcase
      end
      OP_STOP: begin
        case (idx)
          6'd0:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          6'd1:    p = mk(LV_LO,   LV_HOLD, LEN_P, 1'b0);
          6'd2:    p = mk(LV_LO,   LV_HI,   LEN_P, 1'b0);
          default: p = mk(LV_HI,   LV_HI,   LEN_P, 1'b0);
        endcase
      end
      OP_WRITE: begin
        case (idx)
          6'd0:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          6'd1:    p = mk(LV_HOLD, LV_LO,   LEN_P, 1'b0);
          6'd2:    p = mk(dv,      LV_LO,   LEN_P, 1'b0);
          6'd3:    p = mk(dv,      LV_HI,   LEN_P, 1'b0);
          6'd4:    p = mk(LV_HOLD, LV_HOLD, LEN_E, 1'b0);
          default: p = mk(dv,      LV_LO,   LEN_P, 1'b0);
        endcase
      end
      OP_READ: begin
        case (idx)
          6'd0:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          6'd1:    p = mk(LV_HOLD, LV_LO,   LEN_P, 1'b0);
          6'd2:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          6'd3:    p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
          6'd4:    p = mk(LV_HI,   LV_HI,   LEN_P, 1'b1);
          6'd5:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          6'd6:    p = mk(LV_HOLD, LV_HOLD, LEN_E, 1'b0);
          default: p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
        endcase
      end
      OP_ACK, OP_NACK: begin
        case (idx)
          6'd0:    p = mk(LV_HOLD, LV_LO, LEN_P, 1'b0);
          6'd1:    p = mk(lvv,     LV_LO, LEN_P, 1'b0);
          6'd2:    p = mk(lvv,     LV_HI, LEN_A, 1'b0);
          6'd3:    p = mk(lvv,     LV_LO, LEN_P, 1'b0);
          default: p = mk(LV_HI,   LV_LO, LEN_P, 1'b0);
        endcase
      end
      default: begin
        // sample ack
        case (idx)
          6'd0:    p = mk(LV_HOLD, LV_LO,   LEN_P, 1'b0);
          6'd1:    p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
          6'd2:    p = mk(LV_HI,   LV_HI,   LEN_P, 1'b1);
          6'd3:    p = mk(LV_HOLD, LV_HOLD, LEN_P, 1'b0);
          default: p = mk(LV_HI,   LV_LO,   LEN_P, 1'b0);
        endcase
      end
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/i2cbm_if.sv =====
// ----------------------------------------------------------------------------
// i2cbm_if - item channels of the I2C bit-level master
// Command channel in, result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [7:0] wr_data;
  logic       sda_in;

  modport source (output valid, opcode, wr_data, sda_in, input ready);
  modport sink   (input valid, opcode, wr_data, sda_in, output ready);
endinterface

interface i2cbm_res_if;
  logic       valid;
  logic       ready;
  logic       sda_out;
  logic       scl_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_bit;
  logic       rejected;

  modport source (output valid, sda_out, scl_out, busy_res, done_res, read_data,
                  ack_bit, rejected, input ready);
  modport sink   (input valid, sda_out, scl_out, busy_res, done_res, read_data,
                  ack_bit, rejected, output ready);
endinterface

// ===== hdl/i2cbm_front.sv =====
// ----------------------------------------------------------------------------
// i2cbm_front - command intake
// Classifies each item as tick, command or unknown and queues it (two deep).
// ----------------------------------------------------------------------------
module i2cbm_front
  import i2cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cbm_cmd_if.sink   cmd,
  output logic        q_valid,
  output qitem_t      q_item,
  input  logic        q_pop
);

  qitem_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  qitem_t     cls;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = slot[rd_ptr];

  // classify the incoming item
  always_comb begin
    cls.opcode  = cmd.opcode;
    cls.wr_data = cmd.wr_data;
    cls.sda_in  = cmd.sda_in;
    if (cmd.opcode == OP_TICK) begin
      cls.kind = KIND_TICK;
    end else if (cmd.opcode <= OP_SACK) begin
      cls.kind = KIND_CMD;
    end else begin
      cls.kind = KIND_NONE;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/i2cbm_back.sv =====
// ----------------------------------------------------------------------------
// i2cbm_back - phase sequencer
// Runs commands phase by phase on tick items and registers one result per item.
// ----------------------------------------------------------------------------
module i2cbm_back
  import i2cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  qitem_t      q_item,
  output logic        q_pop,
  i2cbm_res_if.source res
);

  // sequencer state
  logic              last_sda, last_scl;
  logic [3:0]        active_cmd;
  logic [5:0]        phase_index;
  logic [TICK_W-1:0] tick_count;
  logic [4:0]        bit_index;
  logic [7:0]        shift_byte;
  logic              sampled_ack;
  logic [7:0]        read_reg;

  logic              last_sda_next, last_scl_next;
  logic [3:0]        active_cmd_next;
  logic [5:0]        phase_index_next;
  logic [TICK_W-1:0] tick_count_next;
  logic [4:0]        bit_index_next;
  logic [7:0]        shift_byte_next;
  logic              sampled_ack_next;
  logic [7:0]        read_reg_next;
  logic              done, rej;

  // effective lengths
  logic [TICK_W-1:0] len_p, len_e, len_a, len_cur;
  logic [4:0]        pulses;
  logic              take;

  // phase bookkeeping
  phase_t            cur_ph, ent_ph;
  logic              ent_en;
  logic [3:0]        ent_cmd;
  logic [5:0]        ent_idx;
  logic [7:0]        sh;
  logic [5:0]        nidx;
  logic              fin;
  logic [4:0]        bn;

  assign len_p  = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
  assign len_e  = cfg.extra_ticks;
  assign len_a  = (cfg.ack_ticks == 16'd0) ? 16'd1 : cfg.ack_ticks;
  assign pulses = (cfg.pulses == 5'd0) ? 5'd1 : cfg.pulses;

  assign take  = q_valid && (!res.valid || res.ready);
  assign q_pop = take;

  assign cur_ph = phase_desc(active_cmd, phase_index, shift_byte[7],
                             active_cmd == OP_NACK);

  always_comb begin
    case (cur_ph.len_sel)
      LEN_E:   len_cur = len_e;
      LEN_A:   len_cur = len_a;
      default: len_cur = len_p;
    endcase
  end

  // next phase of the running command after the current one ends
  always_comb begin
    sh = shift_byte;
    if (cur_ph.sample && active_cmd == OP_READ) begin
      sh = {shift_byte[6:0], q_item.sda_in};
    end
    fin  = 1'b0;
    nidx = phase_index + 6'd1;
    bn   = bit_index;
    case (active_cmd)
      OP_RECOVER: begin
        if (phase_index == 6'd4) begin
          if (({1'b0, bit_index} + 6'd1) < {1'b0, pulses}) begin
            bn   = bit_index + 5'd1;
            nidx = 6'd3;
          end else begin
            nidx = 6'd5;
          end
        end else if (phase_index >= 6'd8) begin
          fin = 1'b1;
        end
      end
      OP_START: fin = (phase_index >= 6'd2);
      OP_STOP:  fin = (phase_index >= 6'd3);
      OP_WRITE: begin
        if (phase_index == 6'd3) begin
          nidx = (bit_index >= 5'd7) ? 6'd4 : 6'd5;
        end else if (phase_index >= 6'd5) begin
          sh = {shift_byte[6:0], 1'b0};
          if (bit_index < 5'd7) begin
            bn   = bit_index + 5'd1;
            nidx = 6'd2;
          end else begin
            fin = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (phase_index == 6'd5) begin
          if (bit_index < 5'd7) begin
            bn   = bit_index + 5'd1;
            nidx = 6'd2;
          end else begin
            nidx = 6'd6;
          end
        end else if (phase_index >= 6'd7) begin
          fin = 1'b1;
        end
      end
      default: fin = (phase_index >= 6'd4);
    endcase
  end

  // item execution
  always_comb begin
    last_sda_next    = last_sda;
    last_scl_next    = last_scl;
    active_cmd_next  = active_cmd;
    phase_index_next = phase_index;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    sampled_ack_next = sampled_ack;
    read_reg_next    = read_reg;
    done             = 1'b0;
    rej              = 1'b0;
    ent_en           = 1'b0;
    ent_cmd          = active_cmd;
    ent_idx          = nidx;

    case (q_item.kind)
      KIND_TICK: begin
        if (active_cmd != CMD_IDLE) begin
          if (({1'b0, tick_count} + 17'd1) >= {1'b0, len_cur}) begin
            if (cur_ph.sample && active_cmd != OP_READ) begin
              sampled_ack_next = q_item.sda_in;
            end
            shift_byte_next = sh;
            bit_index_next  = bn;
            if (fin) begin
              if (active_cmd == OP_READ) begin
                read_reg_next = sh;
              end
              active_cmd_next  = CMD_IDLE;
              phase_index_next = 6'd0;
              tick_count_next  = '0;
              bit_index_next   = 5'd0;
              done             = 1'b1;
            end else begin
              ent_en = 1'b1;
              // an empty extra phase is skipped
              if (len_e == 16'd0 &&
                  ((active_cmd == OP_WRITE && nidx == 6'd4) ||
                   (active_cmd == OP_READ && nidx == 6'd6))) begin
                ent_idx = nidx + 6'd1;
              end
            end
          end else begin
            tick_count_next = tick_count + 1'b1;
          end
        end
      end
      KIND_CMD: begin
        if (active_cmd != CMD_IDLE) begin
          rej = 1'b1;
        end else begin
          active_cmd_next = q_item.opcode;
          bit_index_next  = 5'd0;
          shift_byte_next = (q_item.opcode == OP_WRITE) ? q_item.wr_data : 8'd0;
          ent_en          = 1'b1;
          ent_cmd         = q_item.opcode;
          ent_idx         = 6'd0;
        end
      end
      default: ;
    endcase

    // phase entry: drive the lines and restart the tick count
    ent_ph = phase_desc(ent_cmd, ent_idx, sh[7], ent_cmd == OP_NACK);
    if (ent_en) begin
      if (ent_ph.sda != LV_HOLD) last_sda_next = ent_ph.sda[0];
      if (ent_ph.scl != LV_HOLD) last_scl_next = ent_ph.scl[0];
      phase_index_next = ent_idx;
      tick_count_next  = '0;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sda    <= 1'b1;
      last_scl    <= 1'b1;
      active_cmd  <= CMD_IDLE;
      phase_index <= 6'd0;
      tick_count  <= '0;
      bit_index   <= 5'd0;
      shift_byte  <= 8'd0;
      sampled_ack <= 1'b1;
      read_reg    <= 8'd0;
    end else if (take) begin
      last_sda    <= last_sda_next;
      last_scl    <= last_scl_next;
      active_cmd  <= active_cmd_next;
      phase_index <= phase_index_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      sampled_ack <= sampled_ack_next;
      read_reg    <= read_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.sda_out   <= last_sda_next;
      res.scl_out   <= last_scl_next;
      res.busy_res  <= (active_cmd_next != CMD_IDLE);
      res.done_res  <= done;
      res.read_data <= read_reg_next;
      res.ack_bit   <= sampled_ack_next;
      res.rejected  <= rej;
    end
  end

`ifndef SYNTHESIS
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> res.valid)
    else $error("taken item left no result");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    (active_cmd == CMD_IDLE) |-> (phase_index == 6'd0 && tick_count == '0 &&
                                  bit_index == 5'd0))
    else $error("counters not cleared while idle");

  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    (take && q_item.kind == KIND_CMD && active_cmd != CMD_IDLE) |=> res.rejected)
    else $error("command while busy not flagged");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (take && done) |=> (active_cmd == CMD_IDLE && !res.busy_res))
    else $error("done with a command still running");
`endif

endmodule

// ===== hdl/i2c_bit_level_master.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master - I2C bit-level master
// Drives SDA and SCL phase by phase for recover, start, stop, byte write,
// byte read, ACK, NACK and ACK sampling; ticks advance the phases.
//
//   channel  dir  handshake    payload
//   cmd      in   valid/ready  opcode, wr_data, sda_in
//   res      out  valid/ready  sda_out, scl_out, busy_res, done_res,
//                              read_data, ack_bit, rejected
//   cfg      in   cfg_we       cfg_index, cfg_data
//
// One item per cycle sustained while results are taken; each item's result
// passes the intake queue, then the result register.
// The sequencer computes a whole item's update combinationally.
// Synchronous reset, no clearing pass.
// A two-deep queue parts intake from the sequencer; ready falls only when
// it is full, which happens while results are held back.
// ----------------------------------------------------------------------------
module i2c_bit_level_master
  import i2cbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  i2cbm_cmd_if.sink    cmd,
  i2cbm_res_if.source  res
);

  cfg_t   cfg;
  logic   q_valid;
  qitem_t q_item;
  logic   q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks <= 16'd5;
      cfg.extra_ticks <= 16'd3;
      cfg.ack_ticks   <= 16'd8;
      cfg.pulses      <= 5'd28;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE:  cfg.phase_ticks <= cfg_data;
        CFG_EXTRA:  cfg.extra_ticks <= cfg_data;
        CFG_ACKHI:  cfg.ack_ticks   <= cfg_data;
        CFG_PULSES: cfg.pulses      <= cfg_data[4:0];
        default:    ;
      endcase
    end
  end

  i2cbm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  i2cbm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
